[hdl/ubxp_pkg.sv]
// shared types, constants and field layout tables for the nav frame parser
// no dependencies
package ubxp_pkg;

  localparam int FRAME_BYTES = 98;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [ADDR_W-1:0] SUM_BYTES = ADDR_W'(FRAME_BYTES - 2);
  localparam logic [ADDR_W-1:0] CK_A_POS  = ADDR_W'(FRAME_BYTES - 2);
  localparam logic [ADDR_W-1:0] CK_B_POS  = ADDR_W'(FRAME_BYTES - 1);

  localparam logic [4:0] LAST_FIELD = 5'd28;

  localparam logic [1:0] REG_CLASS = 2'd0;
  localparam logic [1:0] REG_ID    = 2'd1;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_BODY,
    PH_READ,
    PH_CAPTURE,
    PH_PUSH,
    PH_ERROR
  } phase_t;

  // buffer address of the first (least significant) byte of each field
  function automatic logic [ADDR_W-1:0] field_base(input logic [4:0] k);
    logic [ADDR_W-1:0] a;
    case (k)
      5'd0:    a = 7'd4;
      5'd1:    a = 7'd8;
      5'd2:    a = 7'd10;
      5'd3:    a = 7'd11;
      5'd4:    a = 7'd12;
      5'd5:    a = 7'd13;
      5'd6:    a = 7'd14;
      5'd7:    a = 7'd15;
      5'd8:    a = 7'd16;
      5'd9:    a = 7'd20;
      5'd10:   a = 7'd24;
      5'd11:   a = 7'd25;
      5'd12:   a = 7'd26;
      5'd13:   a = 7'd27;
      5'd14:   a = 7'd28;
      5'd15:   a = 7'd32;
      5'd16:   a = 7'd36;
      5'd17:   a = 7'd40;
      5'd18:   a = 7'd44;
      5'd19:   a = 7'd48;
      5'd20:   a = 7'd52;
      5'd21:   a = 7'd56;
      5'd22:   a = 7'd60;
      5'd23:   a = 7'd64;
      5'd24:   a = 7'd68;
      5'd25:   a = 7'd72;
      5'd26:   a = 7'd76;
      5'd27:   a = 7'd80;
      5'd28:   a = 7'd88;
      default: a = 7'd4;
    endcase
    return a;
  endfunction

  // index of the most significant byte of each field (length minus one)
  function automatic logic [1:0] field_top(input logic [4:0] k);
    logic [1:0] t;
    case (k) inside
      5'd0, 5'd8, 5'd9, 5'd28:         t = 2'd3;
      5'd1, 5'd27:                     t = 2'd1;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd7, 5'd10, 5'd11, 5'd12, 5'd13: t = 2'd0;
      default:                         t = 2'd3;
    endcase
    return t;
  endfunction

endpackage

[hdl/ubxp_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module ubxp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 98
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/ubx_nav_pvt_frame_parser_top.sv]
// nav frame parser top level: sync hunt, class/id match, frame buffering,
// fletcher check and field readout; depends on ubxp_pkg and ubxp_ram
//
// rate: one byte transfer per cycle while parsing (in_ready high); after the
// final checksum byte the input stalls for the readout, which reads each field
// byte through the single buffer read port (PH_READ, then PH_CAPTURE) and then
// offers the field (PH_PUSH) once the result slot is free; a bad frame gives
// only the error result, offered from PH_ERROR once the result slot is free
// order: the first field value follows the PH_READ, PH_CAPTURE and PH_PUSH
// states of field 0
// reset: rst_n synchronous active low, clears phase, counters, sums, the
// output valid flag and loads class 0x01 / id 0x07; the frame buffer is left as is
module ubx_nav_pvt_frame_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [4:0]  out_field_index,
  output logic [31:0] out_field_value,
  output logic        out_last,
  // register writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import ubxp_pkg::*;

  // control state
  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;          // buffered byte count / write address
  logic [7:0]        sum_a_r, sum_a_nxt;
  logic [7:0]        sum_b_r, sum_b_nxt;
  logic              ck_a_ok_r, ck_a_ok_nxt;  // first checksum byte matched
  logic [4:0]        fld_r, fld_nxt;          // field being read out
  logic [1:0]        sel_r, sel_nxt;          // byte within the field
  logic [31:0]       acc_r, acc_nxt;          // field assembly

  // configuration
  logic [7:0]        msg_class_r;
  logic [7:0]        msg_id_r;

  // output slot
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [4:0]        out_index_r, out_index_nxt;
  logic [31:0]       out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  // buffer port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic              accept;
  logic              slot_free;
  logic [7:0]        sum_a_add;
  logic [7:0]        sum_b_add;

  ubxp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r),
    .wdata (in_rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // input is taken only in the parsing phases
  assign in_ready  = (phase_r == PH_SYNC1) || (phase_r == PH_SYNC2) ||
                     (phase_r == PH_CLASS) || (phase_r == PH_ID) ||
                     (phase_r == PH_BODY);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // running fletcher sums including the current byte
  assign sum_a_add = sum_a_r + in_rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;

  // read address of the current field byte
  assign ram_raddr = field_base(fld_r) + {{(ADDR_W-2){1'b0}}, sel_r};

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    sum_a_nxt     = sum_a_r;
    sum_b_nxt     = sum_b_r;
    ck_a_ok_nxt   = ck_a_ok_r;
    fld_nxt       = fld_r;
    sel_nxt       = sel_r;
    acc_nxt       = acc_r;
    ram_we        = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    unique case (phase_r) inside
      PH_SYNC1: begin
        if (accept && (in_rx_byte == SYNC_FIRST)) begin
          phase_nxt = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (accept) begin
          // a failed second sync byte is not rechecked as a first one
          phase_nxt = (in_rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
          cnt_nxt   = '0;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
        end
      end
      PH_CLASS, PH_ID: begin
        if (accept) begin
          if (in_rx_byte == ((phase_r == PH_CLASS) ? msg_class_r : msg_id_r)) begin
            ram_we    = 1'b1;
            sum_a_nxt = sum_a_add;
            sum_b_nxt = sum_b_add;
            cnt_nxt   = cnt_r + 1'b1;
            phase_nxt = (phase_r == PH_CLASS) ? PH_ID : PH_BODY;
          end else begin
            phase_nxt = PH_SYNC1;
            cnt_nxt   = '0;
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end
        end
      end
      PH_BODY: begin
        if (accept) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r < SUM_BYTES) begin
            sum_a_nxt = sum_a_add;
            sum_b_nxt = sum_b_add;
          end
          if (cnt_r == CK_A_POS) begin
            ck_a_ok_nxt = (in_rx_byte == sum_a_r);
          end
          if (cnt_r == CK_B_POS) begin
            // frame complete: counters back to hunt values
            cnt_nxt   = '0;
            sum_a_nxt = '0;
            sum_b_nxt = '0;
            fld_nxt   = '0;
            sel_nxt   = '0;
            acc_nxt   = '0;
            phase_nxt = (ck_a_ok_r && (in_rx_byte == sum_b_r)) ? PH_READ : PH_ERROR;
          end
        end
      end
      PH_READ: begin
        // address is presented this cycle, data arrives next cycle
        phase_nxt = PH_CAPTURE;
      end
      PH_CAPTURE: begin
        acc_nxt[{sel_r, 3'b000} +: 8] = ram_rdata;
        if (sel_r == field_top(fld_r)) begin
          phase_nxt = PH_PUSH;
        end else begin
          sel_nxt   = sel_r + 1'b1;
          phase_nxt = PH_READ;
        end
      end
      PH_PUSH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_index_nxt  = fld_r;
          out_value_nxt  = acc_r;
          out_last_nxt   = (fld_r == LAST_FIELD);
          sel_nxt        = '0;
          acc_nxt        = '0;
          if (fld_r == LAST_FIELD) begin
            fld_nxt   = '0;
            phase_nxt = PH_SYNC1;
          end else begin
            fld_nxt   = fld_r + 1'b1;
            phase_nxt = PH_READ;
          end
        end
      end
      PH_ERROR: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          out_index_nxt  = '0;
          out_value_nxt  = '0;
          out_last_nxt   = 1'b1;
          phase_nxt      = PH_SYNC1;
        end
      end
      default: begin
        phase_nxt = PH_SYNC1;
        cnt_nxt   = '0;
        sum_a_nxt = '0;
        sum_b_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      cnt_r       <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      ck_a_ok_r   <= 1'b0;
      fld_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      ck_a_ok_r   <= ck_a_ok_nxt;
      fld_r       <= fld_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_class_r <= 8'h01;
      msg_id_r    <= 8'h07;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLASS: msg_class_r <= cfg_wdata;
        REG_ID:    msg_id_r    <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_field_index = out_index_r;
  assign out_field_value = out_value_r;
  assign out_last        = out_last_r;

endmodule

[tb/nav_frame_checker.sv]
// checker for the nav frame parser: watches the byte, result and register ports,
// keeps its own copy of the parse state and compares every result transfer
// depends on ubxp_pkg for the frame size, sync bytes, register indexes and phases
`timescale 1ns / 1ps

module nav_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_status,
  input  logic [4:0]  out_field_index,
  input  logic [31:0] out_field_value,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);
  import ubxp_pkg::*;

  localparam int FIELD_COUNT   = 29;
  localparam int PAYLOAD_START = 4;  // class, id and two length bytes come first
  localparam int RESERVED_GAP  = 6;  // unused bytes ahead of vehicle heading
  localparam int SUMMED_BYTES  = FRAME_BYTES - 2;

  typedef struct packed {
    logic        status;
    logic [4:0]  index;
    logic [31:0] value;
    logic        last;
  } nav_result_t;

  nav_result_t nav_expected_q[$];
  logic [7:0]  match_class;
  logic [7:0]  match_id;
  phase_t      hunt_state;
  int          fill_count;
  logic [7:0]  frame_copy [0:FRAME_BYTES-1];
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;

  function automatic int field_width(input int k);
    if (k == 1 || k == 27) return 2;
    else if ((k >= 2 && k <= 7) || (k >= 10 && k <= 13)) return 1;
    else return 4;
  endfunction

  task automatic restart_hunt();
    hunt_state = PH_SYNC1;
    fill_count = 0;
    fl_a       = 8'd0;
    fl_b       = 8'd0;
  endtask

  task automatic buffer_byte(input logic [7:0] b);
    if (fill_count < FRAME_BYTES) begin
      frame_copy[fill_count] = b;
      if (fill_count < SUMMED_BYTES) begin
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
      end
      fill_count++;
    end
  endtask

  task automatic predict_frame_end();
    int          off;
    int          w;
    logic [31:0] v;
    nav_result_t r;
    if (fl_a == frame_copy[FRAME_BYTES-2] && fl_b == frame_copy[FRAME_BYTES-1]) begin
      off = 0;
      for (int k = 0; k < FIELD_COUNT; k++) begin
        if (k == FIELD_COUNT - 1) off += RESERVED_GAP;
        w = field_width(k);
        v = 32'd0;
        // little-endian: most significant byte sits highest in the buffer
        for (int j = w - 1; j >= 0; j--) v = {v[23:0], frame_copy[PAYLOAD_START + off + j]};
        r.status = 1'b0;
        r.index  = 5'(k);
        r.value  = v;
        r.last   = (k == FIELD_COUNT - 1);
        nav_expected_q.push_back(r);
        off += w;
      end
    end else begin
      r.status = 1'b1;
      r.index  = 5'd0;
      r.value  = 32'd0;
      r.last   = 1'b1;
      nav_expected_q.push_back(r);
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    case (hunt_state)
      PH_SYNC1: if (b == SYNC_FIRST) hunt_state = PH_SYNC2; else restart_hunt();
      PH_SYNC2: begin
        restart_hunt();
        if (b == SYNC_SECOND) hunt_state = PH_CLASS;
      end
      PH_CLASS: begin
        if (b == match_class) begin
          buffer_byte(b);
          hunt_state = PH_ID;
        end else restart_hunt();
      end
      PH_ID: begin
        if (b == match_id) begin
          buffer_byte(b);
          hunt_state = PH_BODY;
        end else restart_hunt();
      end
      PH_BODY: begin
        buffer_byte(b);
        if (fill_count >= FRAME_BYTES) begin
          predict_frame_end();
          restart_hunt();
        end
      end
      default: restart_hunt();
    endcase
  endtask

  task automatic report_mismatch(input string why, input nav_result_t got,
                                 input nav_result_t want);
    $display("%0t checker: %s: stat %0b/%0b index %0d/%0d value %08h/%08h last %0b/%0b",
             $time, why, got.status, want.status, got.index, want.index,
             got.value, want.value, got.last, want.last);
    fail_count++;
  endtask

  task automatic check_result();
    nav_result_t got;
    nav_result_t want;
    got.status = out_status;
    got.index  = out_field_index;
    got.value  = out_field_value;
    got.last   = out_last;
    if (nav_expected_q.size() == 0) begin
      report_mismatch("result with nothing expected (got/exp)", got, '0);
    end else begin
      want = nav_expected_q.pop_front();
      if (got.status !== want.status || got.index !== want.index ||
          got.value !== want.value || got.last !== want.last)
        report_mismatch("field mismatch (got/exp)", got, want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      match_class = 8'h01;
      match_id    = 8'h07;
      restart_hunt();
      nav_expected_q.delete();
      fail_count  = 0;
      pending    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLASS: match_class = cfg_wdata;
          REG_ID:    match_id    = cfg_wdata;
          default:   ;
        endcase
      end
      if (in_valid && in_ready) take_byte(in_rx_byte);
      if (out_valid && out_ready) check_result();
      pending <= nav_expected_q.size();
    end
  end

endmodule

[tb/tb_ubx_nav_pvt_frame_parser_top.sv]
// testbench top for the nav frame parser: drives bytes, register writes and
// result back-pressure, and gives the verdict from the checker's failure count
// depends on ubxp_pkg, ubx_nav_pvt_frame_parser_top and nav_frame_checker
`timescale 1ns / 1ps

module tb_ubx_nav_pvt_frame_parser_top;
  import ubxp_pkg::*;

  // register indexes the block has no register behind
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int PAYLOAD_LEN = FRAME_BYTES - 6;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 10;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [4:0]  out_field_index;
  logic [31:0] out_field_value;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  int          fail_count;
  int          pending;

  // stimulus knobs, idle and stall chances given in percent
  int          tx_idle_pct;
  int          rx_stall_pct;
  logic        hold_go;
  int          bytes_sent;
  logic [7:0]  cur_class;
  logic [7:0]  cur_id;

  ubx_nav_pvt_frame_parser_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  nav_frame_checker frame_watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // 12 ns clock, low for the first half period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // result back-pressure; the long hold-off is counted here, once, when asked for
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(negedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // one byte transfer; called and returns at a falling edge, valid is left high
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // register write; the idle wait after dropping the enable keeps back-to-back writes from clashing
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid and wait for every expected result, then for the readout tail
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // complete frame: sync, class, id, length, payload and fletcher bytes
  task automatic send_frame(input bit good_sum, input fill_t fill);
    logic [7:0] fr [0:FRAME_BYTES+1];
    logic [7:0] ca;
    logic [7:0] cb;
    fr[0] = SYNC_FIRST;
    fr[1] = SYNC_SECOND;
    fr[2] = cur_class;
    fr[3] = cur_id;
    for (int i = 4; i < FRAME_BYTES; i++) begin
      case (fill)
        FILL_ONES:  fr[i] = 8'hFF;
        FILL_ZEROS: fr[i] = 8'h00;
        default:    fr[i] = rnd_byte();
      endcase
    end
    // length is never checked, so half the random frames carry garbage there
    if (fill == FILL_RANDOM && $urandom_range(0, 1) == 0) begin
      fr[4] = 8'(PAYLOAD_LEN);
      fr[5] = 8'h00;
    end
    ca = 8'h00;
    cb = 8'h00;
    for (int i = 2; i < FRAME_BYTES; i++) begin
      ca += fr[i];
      cb += ca;
    end
    if (!good_sum) begin
      case ($urandom_range(0, 2))
        0: ca ^= 8'($urandom_range(1, 255));
        1: cb ^= 8'($urandom_range(1, 255));
        default: begin
          ca ^= 8'($urandom_range(1, 255));
          cb ^= 8'($urandom_range(1, 255));
        end
      endcase
    end
    fr[FRAME_BYTES]   = ca;
    fr[FRAME_BYTES+1] = cb;
    for (int i = 0; i < FRAME_BYTES + 2; i++) send_byte(fr[i]);
  endtask

  // line noise, with a lone first sync byte now and then
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) send_byte(SYNC_FIRST);
      else send_byte(rnd_byte());
    end
  endtask

  // doubled first sync byte must not sync, nor a first sync byte with a bad second
  task automatic send_broken_sync();
    if ($urandom_range(0, 1) == 0) begin
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(cur_class);
      send_byte(cur_id);
    end else begin
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND ^ 8'($urandom_range(1, 255)));
    end
  endtask

  // good sync, then a class or id that does not match
  task automatic send_wrong_header();
    int n;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    if ($urandom_range(0, 1) == 0) begin
      send_byte(cur_class ^ 8'($urandom_range(1, 255)));
    end else begin
      send_byte(cur_class);
      send_byte(cur_id ^ 8'($urandom_range(1, 255)));
    end
    n = $urandom_range(0, 3);
    repeat (n) send_byte(rnd_byte());
  endtask

  initial begin : stimulus
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    cfg_we       = 1'b0;
    cfg_index    = 2'd0;
    cfg_wdata    = 8'h00;
    rst_n        = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_go      = 1'b0;
    bytes_sent   = 0;
    cur_class    = 8'h01;
    cur_id       = 8'h07;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      // each phase pairs a register setting with an idling pattern
      case (ph)
        0: begin
          cur_class = 8'h01;
          cur_id    = 8'h07;
          write_reg(REG_SPARE_A, 8'hFF);
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          cur_class = 8'h00;
          cur_id    = 8'hFF;
          write_reg(REG_SPARE_B, 8'h00);
          tx_idle_pct  = 55;
          rx_stall_pct = 0;
        end
        2: begin
          cur_class = 8'hFF;
          cur_id    = 8'h00;
          write_reg(REG_SPARE_B, rnd_byte());
          tx_idle_pct  = 0;
          rx_stall_pct = 55;
        end
        default: begin
          // sync values as class and id make the header look like a resync
          cur_class = SYNC_FIRST;
          cur_id    = SYNC_SECOND;
          write_reg(REG_SPARE_A, rnd_byte());
          tx_idle_pct  = 26;
          rx_stall_pct = 26;
          hold_go     <= 1'b1;
        end
      endcase
      write_reg(REG_CLASS, cur_class);
      write_reg(REG_ID, cur_id);

      case (ph)
        0: begin
          // byte extremes and the header failures, all with the default setting
          send_byte(8'h00);
          send_byte(8'hFF);
          send_byte(SYNC_FIRST);
          send_byte(SYNC_FIRST);
          send_byte(SYNC_SECOND);
          send_byte(cur_class);
          send_byte(cur_id);
          send_byte(SYNC_FIRST);
          send_byte(8'h00);
          send_byte(SYNC_FIRST);
          send_byte(SYNC_SECOND);
          send_byte(8'h02);
          send_byte(SYNC_FIRST);
          send_byte(SYNC_SECOND);
          send_byte(cur_class);
          send_byte(8'h06);
          send_byte(SYNC_FIRST);
          send_byte(SYNC_SECOND);
          send_byte(cur_class);
          send_byte(8'hFF);
          // all-ones fields
          send_frame(1'b1, FILL_ONES);
        end
        1: begin
          // header failures and noise with a slow sender
          send_broken_sync();
          send_wrong_header();
          send_noise();
          send_broken_sync();
        end
        2: begin
          // checksum error with a slow receiver
          send_noise();
          send_frame(1'b0, FILL_RANDOM);
          send_noise();
        end
        default: begin
          // the trailing noise is offered while the result side is held off
          send_frame(1'b1, FILL_RANDOM);
          send_noise();
        end
      endcase
    end

    rx_stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
